// ----- sv/aar_pkg.sv -----
`timescale 1ns / 1ps

package aar_pkg;

	// sample and result widths
	localparam int SW     = 24;
	localparam int IDXW   = 16;
	localparam int MAXB   = 16;
	localparam int NRW    = $clog2(MAXB + 1);

	// datapath widths
	localparam int AW     = 40;   // multiplier operand A, signed
	localparam int BW     = 26;   // multiplier operand B, signed
	localparam int PW     = AW + BW;
	localparam int QSW    = 50;   // coefficient sum, signed
	localparam int QMW    = 48;   // coefficient sum magnitude
	localparam int DW     = 34;   // polynomial coefficient
	localparam int HW     = 40;   // Horner accumulator
	localparam int FW     = 48;   // antiderivative and segment area
	localparam int PAW    = 56;   // partial bin area
	localparam int POSW   = 48;   // axis position
	localparam int FRW    = 17;   // position inside one segment
	localparam int MIDW   = 28;   // linear midpoint value
	localparam int DIVSTEP = 4;   // quotient bits per divider cycle
	localparam int DIVCYC = QMW / DIVSTEP;

	// register map
	localparam int ADDRW = 4;
	localparam logic [1:0] REG_MODE  = 2'd0;
	localparam logic [1:0] REG_STEP  = 2'd1;
	localparam logic [1:0] REG_SCALE = 2'd2;
	localparam logic [1:0] REG_COUNT = 2'd3;

	// sequencer states
	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_CMUL = 5'd1;
	localparam logic [4:0] ST_CACC = 5'd2;
	localparam logic [4:0] ST_DIV  = 5'd3;
	localparam logic [4:0] ST_DFIN = 5'd4;
	localparam logic [4:0] ST_F0   = 5'd5;
	localparam logic [4:0] ST_HMUL = 5'd6;
	localparam logic [4:0] ST_HADD = 5'd7;
	localparam logic [4:0] ST_HFIN = 5'd8;
	localparam logic [4:0] ST_LOOP = 5'd9;
	localparam logic [4:0] ST_M0A  = 5'd10;
	localparam logic [4:0] ST_M0B  = 5'd11;
	localparam logic [4:0] ST_M0C  = 5'd12;
	localparam logic [4:0] ST_M0D  = 5'd13;
	localparam logic [4:0] ST_ADD  = 5'd14;
	localparam logic [4:0] ST_MNA  = 5'd15;
	localparam logic [4:0] ST_MNB  = 5'd16;
	localparam logic [4:0] ST_MNC  = 5'd17;
	localparam logic [4:0] ST_EMIT = 5'd18;

	typedef logic signed [SW-1:0] smp_t;
	typedef logic signed [23:0] coef_t;

	// polynomial coefficient table, Q24
	localparam coef_t COEF [6][3] = '{
		'{ 24'sd7161520,  24'sd1214356,  24'sd12733  },
		'{ 24'sd6011574,  24'sd3431217,  24'sd94398  },
		'{-24'sd3640810,  24'sd3364063,  24'sd276747 },
		'{-24'sd4213214,  24'sd708506,   24'sd417539 },
		'{ 24'sd699098,  -24'sd1048646,  24'sd349549 },
		'{ 24'sd1400864, -24'sd700434,   24'sd140088 }
	};

endpackage

// ----- sv/area_average_resampler.sv -----
`timescale 1ns / 1ps

// Channel   | Signals                                  | Direction
// config    | psel penable pwrite paddr pwdata prdata  | APB slave, pready tied high
// input     | in_valid in_ready sample                 | one sample per transfer
// output    | out_valid out_ready bin_value bin_index  | one bin per transfer
//           | last_of_run                              |
//
// One multiplier is shared by all multiply steps under a sequencer; in_ready is high only in idle.
// Mode 0: a linear area step per sample, plus an area step and a mean per closed bin.
// Mode 1: per sample six coefficient sums (each followed by a divide by k+1) and
// two Horner passes, plus a Horner pass and a mean per closed bin.
// A closed bin waits in the output register; the sequencer stalls only when the next
// bin is ready while that register is still full. Reset sets configuration to defaults and clears control.
module area_average_resampler (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [aar_pkg::ADDRW-1:0]     paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [aar_pkg::SW-1:0] sample,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [aar_pkg::SW-1:0] bin_value,
	output logic [aar_pkg::IDXW-1:0]      bin_index,
	output logic                          last_of_run
);
	import aar_pkg::*;

	// configuration
	logic                 mode_q;
	logic [31:0]          step_q;
	logic [20:0]          scale_q;
	logic [IDXW-1:0]      count_q;

	// block state
	smp_t                 win_q [6];
	logic [POSW-1:0]      edge_q;
	logic signed [PAW-1:0] part_q;
	logic [IDXW-1:0]      done_q;
	logic [31:0]          seen_q;
	logic [4:0]           state_q;

	// sequencer control
	logic [POSW-1:0]      start_q;
	logic [FRW-1:0]       u_q;
	logic [FRW-1:0]       b_q;
	logic [NRW-1:0]       nres_q;
	logic                 fin_q;
	logic                 f0_q;
	logic [2:0]           ck_q;
	logic [1:0]           cj_q;
	logic [3:0]           dcnt_q;
	logic [2:0]           hcnt_q;
	logic                 ov_q;

	// datapath
	logic signed [PW-1:0]  mul_q;
	logic signed [QSW-1:0] q_q;
	logic                  neg_q;
	logic [QMW-1:0]        dn_q;
	logic [3:0]            dr_q;
	logic signed [DW-1:0]  d_q [6];
	logic signed [HW-1:0]  h_q;
	logic signed [17:0]    t_q;
	logic signed [FW-1:0]  fu_q;
	logic signed [FW-1:0]  area_q;
	logic signed [MIDW-1:0] mid_q;
	logic [47:0]           p1_q;
	smp_t                  val_q;
	smp_t                  bv_q;
	logic [IDXW-1:0]       bi_q;
	logic                  lr_q;

	// combinational
	logic                  cfg_wr;
	logic                  new_mode;
	logic [31:0]           new_step;
	logic [POSW-1:0]       first_edge;
	logic [31:0]           seen_nx;
	logic                  enough;
	logic [31:0]           seg;
	logic signed [AW-1:0]  op_a;
	logic signed [BW-1:0]  op_b;
	logic signed [PW-1:0]  prod;
	logic signed [24:0]    p_sel;
	logic signed [QSW-1:0] qnew;
	logic [QSW-1:0]        qmag;
	logic [3:0]            dv;
	logic [3:0]            dstep_r;
	logic [QMW-1:0]        dstep_n;
	logic signed [QSW-1:0] quot;
	logic signed [QSW-1:0] quot_r;
	logic signed [DW-1:0]  dnew;
	logic [2:0]            hcnt_m1;
	logic signed [PW-1:0]  rnd16;
	logic signed [HW-1:0]  h_new;
	logic signed [PW-1:0]  rnd8;
	logic signed [FW-1:0]  f_val;
	logic [POSW-1:0]       end_w;
	logic [POSW-1:0]       diff;
	logic [FRW-1:0]        e_raw;
	logic [FRW-1:0]        e_val;
	logic                  cond;
	logic [FRW-1:0]        b_next;
	logic [POSW:0]         edge_sum;
	logic [POSW-1:0]       edge_nx;
	logic                  last_w;
	logic signed [24:0]    dy;
	logic [FRW:0]          sumab;
	logic [FRW-1:0]        wid;
	logic signed [PW-1:0]  acc_mid;
	logic [PAW-1:0]        mag;
	logic [54:0]           lo_r;
	logic [48:0]           rr;
	logic [48:0]           rc;
	logic signed [PAW:0]   psum;
	logic signed [PAW-1:0] psat;
	logic                  slot_free;

	assign pready      = 1'b1;
	assign in_ready    = (state_q == ST_IDLE);
	assign out_valid   = ov_q;
	assign bin_value   = bv_q;
	assign bin_index   = bi_q;
	assign last_of_run = lr_q;
	assign slot_free   = !ov_q || out_ready;

	// decode register writes and the first bin edge they imply
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign new_mode = (cfg_wr && paddr[3:2] == REG_MODE) ? pwdata[0] : mode_q;
	assign new_step = (cfg_wr && paddr[3:2] == REG_STEP) ? pwdata : step_q;
	assign first_edge = {16'b0, new_step} + (new_mode ? POSW'(2 * 65536) : '0);

	// register readback
	always_comb begin
		case (paddr[3:2])
			REG_MODE:  prdata = {31'b0, mode_q};
			REG_STEP:  prdata = step_q;
			REG_SCALE: prdata = {11'b0, scale_q};
			REG_COUNT: prdata = {16'b0, count_q};
			default:   prdata = '0;
		endcase
	end

	// sample counter and segment start for the incoming sample
	assign seen_nx = (seen_q == 32'hFFFF_FFFF) ? seen_q : seen_q + 32'd1;
	assign enough  = mode_q ? (seen_nx >= 32'd6) : (seen_nx >= 32'd2);
	assign seg     = mode_q ? seen_nx - 32'd4 : seen_nx - 32'd2;

	// symmetric window sums and differences
	always_comb begin
		case (cj_q)
			2'd0:    p_sel = ck_q[0] ? ($signed({win_q[3][SW-1], win_q[3]}) - win_q[2])
			                         : ($signed({win_q[3][SW-1], win_q[3]}) + win_q[2]);
			2'd1:    p_sel = ck_q[0] ? ($signed({win_q[4][SW-1], win_q[4]}) - win_q[1])
			                         : ($signed({win_q[4][SW-1], win_q[4]}) + win_q[1]);
			default: p_sel = ck_q[0] ? ($signed({win_q[5][SW-1], win_q[5]}) - win_q[0])
			                         : ($signed({win_q[5][SW-1], win_q[5]}) + win_q[0]);
		endcase
	end

	// linear mode terms
	assign dy    = $signed({win_q[5][SW-1], win_q[5]}) - win_q[4];
	assign sumab = {1'b0, u_q} + {1'b0, b_q};
	assign wid   = b_q - u_q;

	// bin area magnitude for the mean
	assign mag = part_q[PAW-1] ? (PAW'(0) - PAW'(part_q)) : PAW'(part_q);

	// select operands of the shared multiplier
	always_comb begin
		op_a = '0;
		op_b = '0;
		case (state_q)
			ST_CMUL: begin
				op_a = AW'(COEF[ck_q][cj_q]);
				op_b = BW'(p_sel);
			end
			ST_HMUL: begin
				op_a = h_q;
				op_b = BW'(t_q);
			end
			ST_M0A: begin
				op_a = AW'(dy);
				op_b = BW'($signed({1'b0, sumab}));
			end
			ST_M0C: begin
				op_a = AW'(mid_q);
				op_b = BW'($signed({1'b0, wid}));
			end
			ST_MNA: begin
				op_a = $signed({16'b0, mag[55:32]});
				op_b = $signed({5'b0, scale_q});
			end
			ST_MNB: begin
				op_a = $signed({8'b0, mag[31:0]});
				op_b = $signed({5'b0, scale_q});
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	assign prod = op_a * op_b;

	// coefficient sum and its magnitude
	assign qnew = ((cj_q == 2'd0) ? QSW'(0) : q_q) + $signed(mul_q[QSW-1:0]);
	assign qmag = qnew[QSW-1] ? QSW'(0) - QSW'(qnew) : QSW'(qnew);

	// divide by k+1, DIVSTEP quotient bits per cycle
	assign dv = {1'b0, ck_q} + 4'd1;
	always_comb begin
		logic [3:0]     r;
		logic [QMW-1:0] n;
		r = dr_q;
		n = dn_q;
		for (int i = 0; i < DIVSTEP; i++) begin
			r = {r[2:0], n[QMW-1]};
			n = {n[QMW-2:0], 1'b0};
			if (r >= dv) begin
				r = r - dv;
				n[0] = 1'b1;
			end
		end
		dstep_r = r;
		dstep_n = n;
	end

	// truncated quotient, then round away 16 bits
	assign quot   = neg_q ? (QSW'(0) - $signed({2'b0, dn_q})) : $signed({2'b0, dn_q});
	assign quot_r = (quot + QSW'(32768)) >>> 16;
	assign dnew   = quot_r[DW-1:0];

	// Horner step and final scaling
	assign hcnt_m1 = hcnt_q - 3'd1;
	assign rnd16   = (mul_q + PW'(32768)) >>> 16;
	assign h_new   = HW'(d_q[hcnt_m1]) + $signed(rnd16[HW-1:0]);
	assign rnd8    = (mul_q + PW'(128)) >>> 8;
	assign f_val   = rnd8[FW-1:0];

	// next bin edge inside the current segment
	assign end_w = start_q + POSW'(65536);
	assign diff  = edge_q - start_q;
	assign e_raw = (edge_q < start_q) ? '0 : diff[FRW-1:0];
	assign e_val = (e_raw < u_q) ? u_q : e_raw;
	assign cond  = (done_q < count_q) && (nres_q < NRW'(MAXB)) && (edge_q <= end_w);
	assign b_next = cond ? e_val : FRW'(65536);

	// advance the edge with saturation, and look ahead for the last bin of this sample
	assign edge_sum = {1'b0, edge_q} + {17'b0, step_q};
	assign edge_nx  = edge_sum[POSW] ? '1 : edge_sum[POSW-1:0];
	assign last_w   = !((({1'b0, done_q} + 17'd1) < {1'b0, count_q}) &&
	                    ((nres_q + NRW'(1)) < NRW'(MAXB)) && (edge_nx <= end_w));

	// midpoint of the linear segment
	assign acc_mid = ((PW'(win_q[4])) <<< 17) + mul_q + PW'(65536);

	// mean: scale the magnitude, round, saturate
	assign lo_r = {1'b0, mul_q[53:0]} + 55'h0_8000_0000;
	assign rr   = {1'b0, p1_q} + {26'b0, lo_r[54:32]};
	always_comb begin
		if (part_q[PAW-1])
			rc = (rr > 49'(1 << (SW - 1))) ? 49'(1 << (SW - 1)) : rr;
		else
			rc = (rr > 49'((1 << (SW - 1)) - 1)) ? 49'((1 << (SW - 1)) - 1) : rr;
	end

	// saturating bin area accumulate
	assign psum = $signed({part_q[PAW-1], part_q}) + (PAW + 1)'(area_q);
	always_comb begin
		if (psum[PAW] != psum[PAW-1])
			psat = psum[PAW] ? {1'b1, {(PAW-1){1'b0}}} : {1'b0, {(PAW-1){1'b1}}};
		else
			psat = psum[PAW-1:0];
	end

	// control state and sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= 1'b0;
			step_q  <= 32'd65536;
			scale_q <= 21'd65536;
			count_q <= 16'd1024;
			for (int i = 0; i < 6; i++)
				win_q[i] <= '0;
			edge_q  <= POSW'(65536);
			part_q  <= '0;
			done_q  <= '0;
			seen_q  <= '0;
			state_q <= ST_IDLE;
			start_q <= '0;
			u_q     <= '0;
			b_q     <= '0;
			nres_q  <= '0;
			fin_q   <= 1'b0;
			f0_q    <= 1'b0;
			ck_q    <= '0;
			cj_q    <= '0;
			dcnt_q  <= '0;
			hcnt_q  <= '0;
			ov_q    <= 1'b0;
		end else begin
			// take register writes; before the first sample, move the first edge
			if (cfg_wr) begin
				case (paddr[3:2])
					REG_MODE:  mode_q  <= pwdata[0];
					REG_STEP:  step_q  <= pwdata;
					REG_SCALE: scale_q <= pwdata[20:0];
					REG_COUNT: count_q <= pwdata[15:0];
					default:   mode_q  <= mode_q;
				endcase
				if (seen_q == '0 && done_q == '0)
					edge_q <= first_edge;
			end

			// drop the output once transferred, unless the next bin takes its place
			if (ov_q && out_ready && state_q != ST_EMIT)
				ov_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (in_valid && done_q < count_q) begin
						for (int i = 0; i < 5; i++)
							win_q[i] <= win_q[i + 1];
						win_q[5] <= sample;
						seen_q   <= seen_nx;
						start_q  <= {seg[POSW-17:0], 16'b0};
						u_q      <= '0;
						nres_q   <= '0;
						if (enough) begin
							if (mode_q) begin
								ck_q    <= '0;
								cj_q    <= '0;
								state_q <= ST_CMUL;
							end else begin
								state_q <= ST_LOOP;
							end
						end
					end
				end
				ST_CMUL: state_q <= ST_CACC;
				ST_CACC: begin
					if (cj_q == 2'd2) begin
						dcnt_q  <= '0;
						state_q <= ST_DIV;
					end else begin
						cj_q    <= cj_q + 2'd1;
						state_q <= ST_CMUL;
					end
				end
				ST_DIV: begin
					dcnt_q <= dcnt_q + 4'd1;
					if (dcnt_q == 4'(DIVCYC - 1))
						state_q <= ST_DFIN;
				end
				ST_DFIN: begin
					if (ck_q == 3'd5) begin
						state_q <= ST_F0;
					end else begin
						ck_q    <= ck_q + 3'd1;
						cj_q    <= '0;
						state_q <= ST_CMUL;
					end
				end
				ST_F0: begin
					hcnt_q  <= 3'd5;
					f0_q    <= 1'b1;
					state_q <= ST_HMUL;
				end
				ST_HMUL: state_q <= (hcnt_q != 3'd0) ? ST_HADD : ST_HFIN;
				ST_HADD: begin
					hcnt_q  <= hcnt_m1;
					state_q <= ST_HMUL;
				end
				ST_HFIN: begin
					f0_q    <= 1'b0;
					state_q <= f0_q ? ST_LOOP : ST_ADD;
				end
				ST_LOOP: begin
					b_q <= b_next;
					if (cond || done_q < count_q) begin
						fin_q <= !cond;
						if (mode_q) begin
							hcnt_q  <= 3'd5;
							f0_q    <= 1'b0;
							state_q <= ST_HMUL;
						end else begin
							state_q <= ST_M0A;
						end
					end else begin
						part_q  <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_M0A: state_q <= ST_M0B;
				ST_M0B: state_q <= ST_M0C;
				ST_M0C: state_q <= ST_M0D;
				ST_M0D: state_q <= ST_ADD;
				ST_ADD: begin
					part_q  <= psat;
					state_q <= fin_q ? ST_IDLE : ST_MNA;
				end
				ST_MNA: state_q <= ST_MNB;
				ST_MNB: state_q <= ST_MNC;
				ST_MNC: state_q <= ST_EMIT;
				ST_EMIT: begin
					// hold until the output register is free, then close the bin
					if (slot_free) begin
						ov_q    <= 1'b1;
						part_q  <= '0;
						u_q     <= b_q;
						done_q  <= done_q + 16'd1;
						edge_q  <= edge_nx;
						nres_q  <= nres_q + NRW'(1);
						state_q <= ST_LOOP;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		mul_q <= prod;
		case (state_q)
			ST_CACC: begin
				q_q <= qnew;
				if (cj_q == 2'd2) begin
					neg_q <= qnew[QSW-1];
					dn_q  <= qmag[QMW-1:0];
					dr_q  <= '0;
				end
			end
			ST_DIV: begin
				dn_q <= dstep_n;
				dr_q <= dstep_r;
			end
			ST_DFIN: d_q[ck_q] <= dnew;
			ST_F0: begin
				h_q <= HW'(d_q[5]);
				t_q <= -18'sd32768;
			end
			ST_HADD: h_q <= h_new;
			ST_HFIN: begin
				fu_q <= f_val;
				if (!f0_q)
					area_q <= f_val - fu_q;
			end
			ST_LOOP: begin
				h_q <= HW'(d_q[5]);
				t_q <= $signed({1'b0, b_next}) - 18'sd32768;
			end
			ST_M0B: mid_q  <= acc_mid[17 +: MIDW];
			ST_M0D: area_q <= mul_q[FW-1:0];
			ST_MNB: p1_q   <= mul_q[47:0];
			ST_MNC: val_q  <= part_q[PAW-1] ? (SW'(0) - rc[SW-1:0]) : rc[SW-1:0];
			ST_EMIT: begin
				if (slot_free) begin
					bv_q <= val_q;
					bi_q <= done_q;
					lr_q <= last_w;
				end
			end
			default: q_q <= q_q;
		endcase
	end

endmodule
